// ===== rtl/preemptive_priority_scheduler_top_macros.svh =====
// ----------------------------------------------------------------------------
// Preemptive priority scheduler assertion macros
// Shared concurrent assertion forms used by the scheduler RTL.
// ----------------------------------------------------------------------------
`ifndef PREEMPTIVE_PRIORITY_SCHEDULER_TOP_MACROS_SVH
`define PREEMPTIVE_PRIORITY_SCHEDULER_TOP_MACROS_SVH

// same-cycle implication
`define PPS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pps assertion failed");

// next-cycle implication
`define PPS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pps assertion failed");

`endif

// ===== rtl/pps_pkg.sv =====
// ----------------------------------------------------------------------------
// Preemptive priority scheduler package
// Shared types and constants for the scheduler.
// ----------------------------------------------------------------------------
package pps_pkg;

	localparam int QUEUE_DEPTH = 16;

	typedef struct packed {
		logic       arrival_valid;
		logic [7:0] job_id;
		logic [9:0] burst_length;
		logic [7:0] job_priority;
	} job_t;

	typedef struct packed {
		logic        busy_res;
		logic [7:0]  running_id;
		logic        finished;
		logic [15:0] wait_time;
		logic [15:0] turnaround_time;
		logic        arrival_dropped;
	} result_t;

	typedef struct packed {
		logic [7:0]  id;
		logic [9:0]  remaining;
		logic [7:0]  prio;
		logic [15:0] arrival;
		logic [15:0] wait_t;
		logic        started;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

endpackage

// ===== rtl/pps_in_if.sv =====
// ----------------------------------------------------------------------------
// Scheduler tick channel
// Valid/ready channel carrying one tick with an optional arriving job.
// ----------------------------------------------------------------------------
interface pps_in_if;
	logic       valid;
	logic       ready;
	logic       arrival_valid;
	logic [7:0] job_id;
	logic [9:0] burst_length;
	logic [7:0] job_priority;

	modport source (output valid, arrival_valid, job_id, burst_length, job_priority,
		input ready);
	modport sink (input valid, arrival_valid, job_id, burst_length, job_priority,
		output ready);
endinterface

// ===== rtl/pps_out_if.sv =====
// ----------------------------------------------------------------------------
// Scheduler report channel
// Valid/ready channel carrying the outcome of one tick.
// ----------------------------------------------------------------------------
interface pps_out_if;
	logic        valid;
	logic        ready;
	logic        busy_res;
	logic [7:0]  running_id;
	logic        finished;
	logic [15:0] wait_time;
	logic [15:0] turnaround_time;
	logic        arrival_dropped;

	modport source (output valid, busy_res, running_id, finished, wait_time,
		turnaround_time, arrival_dropped, input ready);
	modport sink (input valid, busy_res, running_id, finished, wait_time,
		turnaround_time, arrival_dropped, output ready);
endinterface

// ===== rtl/preemptive_priority_scheduler_top.sv =====
// ----------------------------------------------------------------------------
// Preemptive priority scheduler
// Each accepted tick may enqueue one job, then runs the best queued job for
// one tick and reports the outcome. When no job is queued, the arrival
// included, the scan is skipped; otherwise one queue RAM read port drives a
// linear priority scan over all queued jobs, then the entries behind the
// chosen job are compacted one entry per cycle. The report register lets the
// next tick be accepted while a report waits to be taken.
// ----------------------------------------------------------------------------
module preemptive_priority_scheduler_top #(
	parameter int QUEUE_DEPTH = pps_pkg::QUEUE_DEPTH
) (
	input logic     clk,
	input logic     arst_n,
	pps_in_if.sink  arrival,
	pps_out_if.source report
);

	pps_pkg::job_t    job;
	pps_pkg::result_t res;
	logic             res_valid;
	logic             res_ready;
	logic             out_valid_q;
	pps_pkg::result_t out_q;

	assign job.arrival_valid = arrival.arrival_valid;
	assign job.job_id        = arrival.job_id;
	assign job.burst_length  = arrival.burst_length;
	assign job.job_priority  = arrival.job_priority;

	pps_core #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (arrival.valid),
		.job_ready (arrival.ready),
		.job       (job),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	assign res_ready = !out_valid_q || report.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (report.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign report.valid           = out_valid_q;
	assign report.busy_res        = out_q.busy_res;
	assign report.running_id      = out_q.running_id;
	assign report.finished        = out_q.finished;
	assign report.wait_time       = out_q.wait_time;
	assign report.turnaround_time = out_q.turnaround_time;
	assign report.arrival_dropped = out_q.arrival_dropped;

endmodule

// ===== rtl/pps_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module pps_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/pps_core.sv =====
// ----------------------------------------------------------------------------
// Scheduler core
// Sequencer that appends, scans for the best entry, compacts and requeues.
// ----------------------------------------------------------------------------
`include "preemptive_priority_scheduler_top_macros.svh"

module pps_core #(
	parameter int QUEUE_DEPTH = pps_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             job_valid,
	output logic             job_ready,
	input  pps_pkg::job_t    job,
	output logic             res_valid,
	input  logic             res_ready,
	output pps_pkg::result_t res
);

	localparam int IDX_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_SCAN   = 5'b00010,
		ST_SHIFT  = 5'b00100,
		ST_UPDATE = 5'b01000,
		ST_DONE   = 5'b10000
	} state_t;

	state_t            state_q;
	logic [CNT_W-1:0]  count_q;
	logic [15:0]       tick_q;
	logic [CNT_W-1:0]  ptr_q;
	logic              rvld_s1;
	logic [IDX_W-1:0]  ridx_s1;
	pps_pkg::entry_t   best_q;
	logic [IDX_W-1:0]  best_idx_q;
	logic              drop_q;
	pps_pkg::result_t  res_q;

	logic              accept;
	logic              full;
	logic              issue;
	logic              take;
	logic [CNT_W-1:0]  cnt_dec;
	pps_pkg::entry_t   new_entry;
	pps_pkg::entry_t   upd_entry;
	logic [15:0]       upd_wait;
	logic              upd_fin;

	logic                      ram_we;
	logic [IDX_W-1:0]          ram_waddr;
	logic [pps_pkg::ENTRY_W-1:0] ram_wdata;
	logic [IDX_W-1:0]          ram_raddr;
	logic [pps_pkg::ENTRY_W-1:0] ram_rdata;
	pps_pkg::entry_t           rd_entry;

	pps_ram #(
		.WIDTH (pps_pkg::ENTRY_W),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign rd_entry  = pps_pkg::entry_t'(ram_rdata);
	assign job_ready = (state_q == ST_IDLE);
	assign accept    = job_valid && job_ready;
	assign full      = (count_q == CNT_W'(QUEUE_DEPTH));
	assign issue     = ((state_q == ST_SCAN) || (state_q == ST_SHIFT)) && (ptr_q < count_q);
	assign ram_raddr = ptr_q[IDX_W-1:0];
	assign cnt_dec   = count_q - CNT_W'(1);

	// priority comparator: the lower value wins, a tie keeps the earlier entry
	assign take = rvld_s1 && ((ridx_s1 == '0) || (rd_entry.prio < best_q.prio));

	always_comb begin
		new_entry.id        = job.job_id;
		new_entry.remaining = (job.burst_length == '0) ? 10'd1 : job.burst_length;
		new_entry.prio      = job.job_priority;
		new_entry.arrival   = tick_q;
		new_entry.wait_t    = '0;
		new_entry.started   = 1'b0;
	end

	always_comb begin
		upd_wait            = best_q.started ? best_q.wait_t : (tick_q - best_q.arrival);
		upd_fin             = (best_q.remaining <= 10'd1);
		upd_entry           = best_q;
		upd_entry.remaining = best_q.remaining - 10'd1;
		upd_entry.wait_t    = upd_wait;
		upd_entry.started   = 1'b1;
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = count_q[IDX_W-1:0];
		ram_wdata = new_entry;
		unique case (state_q)
			ST_IDLE: begin
				ram_we = accept && job.arrival_valid && !full;
			end
			ST_SHIFT: begin
				ram_we    = rvld_s1;
				ram_waddr = ridx_s1 - IDX_W'(1);
				ram_wdata = ram_rdata;
			end
			ST_UPDATE: begin
				ram_we    = !upd_fin;
				ram_waddr = cnt_dec[IDX_W-1:0];
				ram_wdata = upd_entry;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			tick_q  <= '0;
			ptr_q   <= '0;
			rvld_s1 <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					rvld_s1 <= 1'b0;
					ptr_q   <= '0;
					if (accept) begin
						if (ram_we) begin
							count_q <= count_q + CNT_W'(1);
							state_q <= ST_SCAN;
						end else if (count_q != '0) begin
							state_q <= ST_SCAN;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_SCAN: begin
					rvld_s1 <= issue;
					if (issue) begin
						ptr_q <= ptr_q + CNT_W'(1);
					end
					if (!issue && !rvld_s1) begin
						ptr_q   <= CNT_W'(best_idx_q) + CNT_W'(1);
						state_q <= ST_SHIFT;
					end
				end
				ST_SHIFT: begin
					rvld_s1 <= issue;
					if (issue) begin
						ptr_q <= ptr_q + CNT_W'(1);
					end else begin
						state_q <= ST_UPDATE;
					end
				end
				ST_UPDATE: begin
					if (upd_fin) begin
						count_q <= cnt_dec;
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (res_ready) begin
						tick_q  <= tick_q + 16'd1;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			ridx_s1 <= ptr_q[IDX_W-1:0];
		end
		if ((state_q == ST_SCAN) && take) begin
			best_q     <= rd_entry;
			best_idx_q <= ridx_s1;
		end
		if (accept) begin
			drop_q <= job.arrival_valid && full;
			res_q  <= '{arrival_dropped: job.arrival_valid && full, default: '0};
		end
		if (state_q == ST_UPDATE) begin
			res_q.busy_res        <= 1'b1;
			res_q.running_id      <= best_q.id;
			res_q.finished        <= upd_fin;
			res_q.wait_time       <= upd_fin ? upd_wait : 16'd0;
			res_q.turnaround_time <= upd_fin ? (tick_q + 16'd1 - best_q.arrival) : 16'd0;
			res_q.arrival_dropped <= drop_q;
		end
	end

	assign res_valid = (state_q == ST_DONE);
	assign res       = res_q;

	`PPS_ASSERT_IMP(a_count_bound, clk, arst_n, 1'b1, count_q <= CNT_W'(QUEUE_DEPTH))
	`PPS_ASSERT_IMP(a_scan_nonempty, clk, arst_n, state_q == ST_SCAN, count_q != '0)
	`PPS_ASSERT_NXT(a_finish_leaves, clk, arst_n, (state_q == ST_UPDATE) && upd_fin, count_q == $past(cnt_dec))

endmodule
